/* rtl/pav_pkg.sv */
`default_nettype none
package pav_pkg;

	localparam int VALUE_W = 24;
	localparam int MAG_W = VALUE_W;
	localparam int CFG_W = 23;
	localparam int DT_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int LZ_W = 5;

	// Unit vector component, Q0.30 magnitude, at most 2^30
	localparam int U_W = 31;
	localparam int ROOT_W = 32;
	localparam int RAD_W = 64;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS = U_W;
	// normalize, square, sum, then root and quotient chains
	localparam int UNIT_LAT = 3 + SQRT_STEPS + DIV_STEPS;

	localparam logic [CFG_W-1:0] MAX_SPEED_RST = 23'd61440;
	localparam logic [CFG_W-1:0] MIN_DIST_RST = 23'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_SPEED = 1'b0,
		REG_MIN_DIST = 1'b1
	} cfg_reg_t;

endpackage
`default_nettype wire

/* rtl/pav_in_if.sv */
`default_nettype none
interface pav_in_if import pav_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VALUE_W-1:0] target_x;
	logic signed [VALUE_W-1:0] target_y;
	logic signed [VALUE_W-1:0] pos_x;
	logic signed [VALUE_W-1:0] pos_y;
	logic signed [VALUE_W-1:0] vel_in_x;
	logic signed [VALUE_W-1:0] vel_in_y;
	logic signed [VALUE_W-1:0] pull;
	logic [DT_W-1:0] step_time;

	modport source (output valid, target_x, target_y, pos_x, pos_y, vel_in_x, vel_in_y,
		pull, step_time, input ready);
	modport sink (input valid, target_x, target_y, pos_x, pos_y, vel_in_x, vel_in_y,
		pull, step_time, output ready);
endinterface
`default_nettype wire

/* rtl/pav_out_if.sv */
`default_nettype none
interface pav_out_if import pav_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VALUE_W-1:0] vel_out_x;
	logic signed [VALUE_W-1:0] vel_out_y;
	logic too_close;
	logic was_limited;

	modport source (output valid, vel_out_x, vel_out_y, too_close, was_limited, input ready);
	modport sink (input valid, vel_out_x, vel_out_y, too_close, was_limited, output ready);
endinterface
`default_nettype wire

/* rtl/point_attractor_velocity_step.sv */
// Channel    Dir  Payload
// particle   in   target_x/y, pos_x/y, vel_in_x/y, pull, step_time
// result     out  vel_out_x/y, too_close, was_limited
// cfg_*      in   write port, index 0 max_speed, 1 min_distance
//
// One item per cycle while results are taken; the two unit-vector units
// hold 32 root stages plus 31 divider stages each.
// arst_n clears the valid bits and loads the default limits.
// A result that is not taken stalls the whole pipeline in place.
`default_nettype none
module point_attractor_velocity_step import pav_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	pav_in_if.sink                    particle,
	pav_out_if.source                 result
);

	localparam int DLY1 = UNIT_LAT - 2;
	localparam int DLY2 = UNIT_LAT;

	typedef struct packed {
		logic close;
		logic negx;
		logic negy;
		logic pneg;
		logic signed [VALUE_W-1:0] vx;
		logic signed [VALUE_W-1:0] vy;
		logic [MAG_W-1:0] pm;
		logic [DT_W-1:0] dt;
	} side1_t;

	typedef struct packed {
		logic close;
		logic lim;
		logic signed [VALUE_W-1:0] vx;
		logic signed [VALUE_W-1:0] vy;
	} side2_t;

	function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [VALUE_W+1:0] v);
		logic signed [VALUE_W+1:0] hi;
		logic signed [VALUE_W+1:0] lo;
		hi = (VALUE_W+2)'((1 << (VALUE_W - 1)) - 1);
		lo = -(VALUE_W+2)'(1 << (VALUE_W - 1));
		if (v > hi) return hi[VALUE_W-1:0];
		if (v < lo) return lo[VALUE_W-1:0];
		return v[VALUE_W-1:0];
	endfunction

	function automatic logic signed [VALUE_W-1:0] apply_pull(
		input logic signed [VALUE_W-1:0] v, input logic neg, input logic [MAG_W:0] mag);
		logic signed [VALUE_W+1:0] d;
		d = $signed({1'b0, mag});
		if (neg) d = -d;
		return sat_val($signed({{2{v[VALUE_W-1]}}, v}) + d);
	endfunction

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [VALUE_W-1:0] v);
		return v[VALUE_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	logic [CFG_W-1:0] max_speed_q, min_dist_q;
	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [MAG_W-1:0] adx_s1, ady_s1;
	side1_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	logic [2*MAG_W-1:0] sqx_s2, sqy_s2;
	logic [2*CFG_W-1:0] md2_s2;
	logic zero_s2;

	logic [DLY1-1:0] vld1_q;
	side1_t dly1_q [DLY1];
	logic [U_W-1:0] ux, uy;

	logic [U_W+MAG_W-1:0] px_full, py_full;
	logic [U_W+MAG_W-15:0] tx_s4, ty_s4;
	logic [U_W+MAG_W-14+DT_W-1:0] qx_full, qy_full;
	logic [MAG_W:0] mx_s5, my_s5;

	side2_t sd_s6, sd_s7, sd_s8;
	logic [MAG_W-1:0] mvx_s7, mvy_s7, mvx_s8, mvy_s8;
	logic [2*MAG_W-1:0] s2x_s7, s2y_s7;
	logic [2*CFG_W-1:0] ms2_s7;

	logic [DLY2-1:0] vld2_q;
	side2_t dly2_q [DLY2];
	logic [U_W-1:0] sx, sy;
	logic [U_W+CFG_W-1:0] nx_full, ny_full;
	logic [MAG_W-1:0] nx_s9, ny_s9;
	side2_t sd_s9;

	logic signed [VALUE_W:0] dx, dy;
	logic [MAG_W-1:0] out_mag_x, out_mag_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			min_dist_q <= MIN_DIST_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_SPEED: max_speed_q <= cfg_wdata;
				REG_MIN_DIST: min_dist_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en = !result.valid || result.ready;
	assign particle.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
			vld1_q <= '0;
			vld2_q <= '0;
			result.valid <= 1'b0;
		end else if (en) begin
			v_s1 <= particle.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vld1_q <= {vld1_q[DLY1-2:0], v_s3};
			v_s4 <= vld1_q[DLY1-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			vld2_q <= {vld2_q[DLY2-2:0], v_s8};
			v_s9 <= vld2_q[DLY2-1];
			result.valid <= v_s9;
		end
	end

	assign dx = $signed({particle.target_x[VALUE_W-1], particle.target_x})
		- $signed({particle.pos_x[VALUE_W-1], particle.pos_x});
	assign dy = $signed({particle.target_y[VALUE_W-1], particle.target_y})
		- $signed({particle.pos_y[VALUE_W-1], particle.pos_y});

	// offset, distance test and sideband
	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1 <= dx[VALUE_W] ? MAG_W'(-dx) : MAG_W'(dx);
			ady_s1 <= dy[VALUE_W] ? MAG_W'(-dy) : MAG_W'(dy);
			sd_s1.close <= 1'b0;
			sd_s1.negx <= dx[VALUE_W];
			sd_s1.negy <= dy[VALUE_W];
			sd_s1.pneg <= particle.pull[VALUE_W-1];
			sd_s1.vx <= particle.vel_in_x;
			sd_s1.vy <= particle.vel_in_y;
			sd_s1.pm <= mag_of(particle.pull);
			sd_s1.dt <= particle.step_time;

			sqx_s2 <= (2*MAG_W)'(adx_s1) * (2*MAG_W)'(adx_s1);
			sqy_s2 <= (2*MAG_W)'(ady_s1) * (2*MAG_W)'(ady_s1);
			md2_s2 <= (2*CFG_W)'(min_dist_q) * (2*CFG_W)'(min_dist_q);
			zero_s2 <= (adx_s1 == '0) && (ady_s1 == '0);
			sd_s2 <= sd_s1;

			sd_s3.close <= zero_s2
				|| (({1'b0, sqx_s2} + {1'b0, sqy_s2}) < (2*MAG_W+1)'(md2_s2));
			sd_s3.negx <= sd_s2.negx;
			sd_s3.negy <= sd_s2.negy;
			sd_s3.pneg <= sd_s2.pneg;
			sd_s3.vx <= sd_s2.vx;
			sd_s3.vy <= sd_s2.vy;
			sd_s3.pm <= sd_s2.pm;
			sd_s3.dt <= sd_s2.dt;

			dly1_q[0] <= sd_s3;
			for (int i = 1; i < DLY1; i++) dly1_q[i] <= dly1_q[i-1];
		end
	end

	pav_unit u_dir (
		.clk (clk),
		.en  (en),
		.a   (adx_s1),
		.b   (ady_s1),
		.ua  (ux),
		.ub  (uy)
	);

	assign px_full = (U_W+MAG_W)'(ux) * (U_W+MAG_W)'(dly1_q[DLY1-1].pm);
	assign py_full = (U_W+MAG_W)'(uy) * (U_W+MAG_W)'(dly1_q[DLY1-1].pm);
	assign qx_full = (U_W+MAG_W-14+DT_W)'(tx_s4) * (U_W+MAG_W-14+DT_W)'(sd_s4.dt);
	assign qy_full = (U_W+MAG_W-14+DT_W)'(ty_s4) * (U_W+MAG_W-14+DT_W)'(sd_s4.dt);

	// pull increment, velocity sum, speed test
	always_ff @(posedge clk) begin
		if (en) begin
			tx_s4 <= px_full[U_W+MAG_W-1:14];
			ty_s4 <= py_full[U_W+MAG_W-1:14];
			sd_s4 <= dly1_q[DLY1-1];

			mx_s5 <= qx_full[32 +: MAG_W+1];
			my_s5 <= qy_full[32 +: MAG_W+1];
			sd_s5 <= sd_s4;

			sd_s6.close <= sd_s5.close;
			sd_s6.lim <= 1'b0;
			if (sd_s5.close) begin
				sd_s6.vx <= sd_s5.vx;
				sd_s6.vy <= sd_s5.vy;
			end else begin
				sd_s6.vx <= apply_pull(sd_s5.vx, sd_s5.negx ^ sd_s5.pneg, mx_s5);
				sd_s6.vy <= apply_pull(sd_s5.vy, sd_s5.negy ^ sd_s5.pneg, my_s5);
			end

			mvx_s7 <= mag_of(sd_s6.vx);
			mvy_s7 <= mag_of(sd_s6.vy);
			s2x_s7 <= (2*MAG_W)'(mag_of(sd_s6.vx)) * (2*MAG_W)'(mag_of(sd_s6.vx));
			s2y_s7 <= (2*MAG_W)'(mag_of(sd_s6.vy)) * (2*MAG_W)'(mag_of(sd_s6.vy));
			ms2_s7 <= (2*CFG_W)'(max_speed_q) * (2*CFG_W)'(max_speed_q);
			sd_s7 <= sd_s6;

			mvx_s8 <= mvx_s7;
			mvy_s8 <= mvy_s7;
			sd_s8.close <= sd_s7.close;
			sd_s8.lim <= !sd_s7.close
				&& (({1'b0, s2x_s7} + {1'b0, s2y_s7}) > (2*MAG_W+1)'(ms2_s7));
			sd_s8.vx <= sd_s7.vx;
			sd_s8.vy <= sd_s7.vy;

			dly2_q[0] <= sd_s8;
			for (int i = 1; i < DLY2; i++) dly2_q[i] <= dly2_q[i-1];
		end
	end

	pav_unit u_rescale (
		.clk (clk),
		.en  (en),
		.a   (mvx_s8),
		.b   (mvy_s8),
		.ua  (sx),
		.ub  (sy)
	);

	assign nx_full = (U_W+CFG_W)'(sx) * (U_W+CFG_W)'(max_speed_q);
	assign ny_full = (U_W+CFG_W)'(sy) * (U_W+CFG_W)'(max_speed_q);

	// rescale onto the speed limit when it was exceeded, keep the component signs
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s9 <= nx_full[30 +: MAG_W];
			ny_s9 <= ny_full[30 +: MAG_W];
			sd_s9 <= dly2_q[DLY2-1];

			if (sd_s9.lim) begin
				result.vel_out_x <= sd_s9.vx[VALUE_W-1] ? -$signed(nx_s9) : $signed(nx_s9);
				result.vel_out_y <= sd_s9.vy[VALUE_W-1] ? -$signed(ny_s9) : $signed(ny_s9);
			end else begin
				result.vel_out_x <= sd_s9.vx;
				result.vel_out_y <= sd_s9.vy;
			end
			result.too_close <= sd_s9.close;
			result.was_limited <= sd_s9.lim;
		end
	end

	assign out_mag_x = mag_of(result.vel_out_x);
	assign out_mag_y = mag_of(result.vel_out_y);

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.too_close && result.was_limited))
		else $error("too_close and was_limited both set");

	a_limited_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.was_limited
		|-> (out_mag_x <= MAG_W'(max_speed_q)) && (out_mag_y <= MAG_W'(max_speed_q)))
		else $error("rescaled component exceeds max_speed");

	a_unlimited_speed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.too_close && !result.was_limited
		|-> ((2*MAG_W+1)'((2*MAG_W)'(out_mag_x) * (2*MAG_W)'(out_mag_x))
			+ (2*MAG_W+1)'((2*MAG_W)'(out_mag_y) * (2*MAG_W)'(out_mag_y)))
			<= (2*MAG_W+1)'((2*CFG_W)'(max_speed_q) * (2*CFG_W)'(max_speed_q)))
		else $error("unlimited result above max_speed");

endmodule
`default_nettype wire

/* rtl/pav_sqrt.sv */
`default_nettype none
module pav_sqrt import pav_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [RAD_W-1:0]     rad,
	input  wire logic [2*MAG_W-1:0]   side_in,
	output logic      [ROOT_W-1:0]    root,
	output logic      [2*MAG_W-1:0]   side_out
);

	logic [RAD_W-1:0] rem_s [SQRT_STEPS];
	logic [ROOT_W-1:0] root_s [SQRT_STEPS];
	logic [2*MAG_W-1:0] side_s [SQRT_STEPS];

	// one root bit per stage, remainder kept as rad - root^2
	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
		localparam int B = SQRT_STEPS - 1 - g;
		logic [RAD_W-1:0] rem_i;
		logic [ROOT_W-1:0] root_i;
		logic [2*MAG_W-1:0] side_i;
		logic [RAD_W+1:0] trial;
		logic [RAD_W+1:0] rem_w;

		if (g == 0) begin : g_first
			assign rem_i = rad;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign rem_i = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign side_i = side_s[g-1];
		end

		assign rem_w = {2'b00, rem_i};
		assign trial = ({{(RAD_W+2-ROOT_W){1'b0}}, root_i} << (B + 1))
			+ ((RAD_W+2)'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_w >= trial) begin
					rem_s[g] <= RAD_W'(rem_w - trial);
					root_s[g] <= root_i | (ROOT_W'(1) << B);
				end else begin
					rem_s[g] <= rem_i;
					root_s[g] <= root_i;
				end
				side_s[g] <= side_i;
			end
		end
	end

	assign root = root_s[SQRT_STEPS-1];
	assign side_out = side_s[SQRT_STEPS-1];

endmodule
`default_nettype wire

/* rtl/pav_div.sv */
`default_nettype none
module pav_div import pav_pkg::*; (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [RAD_W-1:0]    num,
	input  wire logic [ROOT_W-1:0]   den,
	output logic      [U_W-1:0]      quo
);

	logic [RAD_W-1:0] rem_s [DIV_STEPS];
	logic [ROOT_W-1:0] den_s [DIV_STEPS];
	logic [U_W-1:0] quo_s [DIV_STEPS];

	// restoring division, one quotient bit per stage
	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		localparam int B = DIV_STEPS - 1 - g;
		logic [RAD_W-1:0] rem_i;
		logic [ROOT_W-1:0] den_i;
		logic [U_W-1:0] quo_i;
		logic [RAD_W-1:0] shifted;

		if (g == 0) begin : g_first
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_s[g-1];
			assign den_i = den_s[g-1];
			assign quo_i = quo_s[g-1];
		end

		assign shifted = {{(RAD_W-ROOT_W){1'b0}}, den_i} << B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= shifted) begin
					rem_s[g] <= rem_i - shifted;
					quo_s[g] <= quo_i | (U_W'(1) << B);
				end else begin
					rem_s[g] <= rem_i;
					quo_s[g] <= quo_i;
				end
				den_s[g] <= den_i;
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule
`default_nettype wire

/* rtl/pav_unit.sv */
`default_nettype none
module pav_unit import pav_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [MAG_W-1:0]   a,
	input  wire logic [MAG_W-1:0]   b,
	output logic      [U_W-1:0]     ua,
	output logic      [U_W-1:0]     ub
);

	logic [MAG_W-1:0] big;
	logic [LZ_W-1:0] lz;
	logic [MAG_W-1:0] an_s1, bn_s1;
	logic [2*MAG_W-1:0] sqa_s2, sqb_s2;
	logic [MAG_W-1:0] an_s2, bn_s2;
	logic [RAD_W-1:0] rad_s3;
	logic [MAG_W-1:0] an_s3, bn_s3;
	logic [ROOT_W-1:0] root;
	logic [2*MAG_W-1:0] side;
	logic [RAD_W-1:0] num_a, num_b;

	// shift so the larger magnitude has its top bit set
	always_comb begin
		big = (a > b) ? a : b;
		lz = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (big[i]) lz = LZ_W'(MAG_W - 1 - i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1 <= MAG_W'(a << lz);
			bn_s1 <= MAG_W'(b << lz);
			sqa_s2 <= (2*MAG_W)'(an_s1) * (2*MAG_W)'(an_s1);
			sqb_s2 <= (2*MAG_W)'(bn_s1) * (2*MAG_W)'(bn_s1);
			an_s2 <= an_s1;
			bn_s2 <= bn_s1;
			rad_s3 <= RAD_W'({1'b0, sqa_s2} + {1'b0, sqb_s2}) << 14;
			an_s3 <= an_s2;
			bn_s3 <= bn_s2;
		end
	end

	pav_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.rad      (rad_s3),
		.side_in  ({an_s3, bn_s3}),
		.root     (root),
		.side_out (side)
	);

	assign num_a = RAD_W'(side[2*MAG_W-1:MAG_W]) << 37;
	assign num_b = RAD_W'(side[MAG_W-1:0]) << 37;

	pav_div u_div_a (
		.clk (clk),
		.en  (en),
		.num (num_a),
		.den (root),
		.quo (ua)
	);

	pav_div u_div_b (
		.clk (clk),
		.en  (en),
		.num (num_b),
		.den (root),
		.quo (ub)
	);

endmodule
`default_nettype wire

/* dv/point_attractor_velocity_step_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module point_attractor_velocity_step_tb;
	import pav_pkg::*;

	localparam int DRAIN_CYCLES = 160;
	localparam longint CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 1300;
	localparam int PHASES = 5;

	typedef struct packed {
		logic signed [VALUE_W-1:0] target_x;
		logic signed [VALUE_W-1:0] target_y;
		logic signed [VALUE_W-1:0] pos_x;
		logic signed [VALUE_W-1:0] pos_y;
		logic signed [VALUE_W-1:0] vel_x;
		logic signed [VALUE_W-1:0] vel_y;
		logic signed [VALUE_W-1:0] pull;
		logic [DT_W-1:0] step_time;
	} particle_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] vel_x;
		logic signed [VALUE_W-1:0] vel_y;
		logic too_close;
		logic was_limited;
	} velocity_t;

	typedef struct packed {
		particle_t p;
		logic typed;
		velocity_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	pav_in_if particle ();
	pav_out_if result ();

	point_attractor_velocity_step dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .particle(particle.sink), .result(result.source)
	);

	velocity_t pending_vel[$];
	int errors = 0;
	bit calm = 0;
	longint unsigned speed_cap = 64'(MAX_SPEED_RST);
	longint unsigned near_radius = 64'(MIN_DIST_RST);
	longint cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic longint unsigned int_root(input longint unsigned x);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// Q0.30 direction magnitudes; a or b must be nonzero
	function automatic void unit_vec(input longint unsigned a, input longint unsigned b,
			output longint unsigned ua, output longint unsigned ub);
		longint unsigned m = (a > b) ? a : b;
		longint unsigned r;
		while (m >= (64'd1 << 24)) begin
			a >>= 1; b >>= 1; m >>= 1;
		end
		while (m < (64'd1 << 23)) begin
			a <<= 1; b <<= 1; m <<= 1;
		end
		r = int_root((a * a + b * b) << 14);
		if (r == 0) r = 1;
		ua = (a << 37) / r;
		ub = (b << 37) / r;
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint clip(input longint v);
		longint lim = 64'sd1 <<< (VALUE_W - 1);
		if (v > lim - 1) return lim - 1;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint nudge(input longint unsigned u, input bit neg,
			input longint unsigned pm, input longint unsigned dt);
		longint unsigned m = (((u * pm) >> 14) * dt) >> 32;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic velocity_t attract(input particle_t p);
		velocity_t o;
		longint vx = longint'(p.vel_x), vy = longint'(p.vel_y), pl = longint'(p.pull);
		longint dx = longint'(p.target_x) - longint'(p.pos_x);
		longint dy = longint'(p.target_y) - longint'(p.pos_y);
		longint unsigned adx = mag(dx), ady = mag(dy);
		longint unsigned dt = 64'(p.step_time);
		longint unsigned ux, uy, sx, sy;
		bit near;
		o.was_limited = 0;
		if (adx == 0 && ady == 0) near = 1;
		else if (adx >= (64'd1 << 24) || ady >= (64'd1 << 24)) near = 0;
		else near = (adx * adx + ady * ady) < (near_radius * near_radius);
		if (!near) begin
			unit_vec(adx, ady, ux, uy);
			vx = clip(vx + nudge(ux, (dx < 0) != (pl < 0), mag(pl), dt));
			vy = clip(vy + nudge(uy, (dy < 0) != (pl < 0), mag(pl), dt));
			if (longint'(mag(vx) * mag(vx) + mag(vy) * mag(vy)) >
					longint'(speed_cap * speed_cap)) begin
				unit_vec(mag(vx), mag(vy), sx, sy);
				vx = clip((vx < 0) ? -longint'((sx * speed_cap) >> 30)
					: longint'((sx * speed_cap) >> 30));
				vy = clip((vy < 0) ? -longint'((sy * speed_cap) >> 30)
					: longint'((sy * speed_cap) >> 30));
				o.was_limited = 1;
			end
		end
		o.vel_x = vx[VALUE_W-1:0];
		o.vel_y = vy[VALUE_W-1:0];
		o.too_close = near;
		return o;
	endfunction

	function automatic logic [VALUE_W-1:0] any_value();
		case ($urandom_range(0, 4))
			0: return 24'($urandom);
			1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			2: return 24'($signed($urandom_range(0, 4000)) - 2000);
			default: return 24'($signed($urandom_range(0, 200000)) - 100000);
		endcase
	endfunction

	function automatic particle_t random_particle();
		particle_t p;
		p.target_x = any_value();
		p.target_y = any_value();
		case ($urandom_range(0, 5))
			0: begin p.pos_x = p.target_x; p.pos_y = p.target_y; end
			1, 2: begin
				p.pos_x = p.target_x + 24'($signed($urandom_range(0, 1200)) - 600);
				p.pos_y = p.target_y + 24'($signed($urandom_range(0, 1200)) - 600);
			end
			default: begin p.pos_x = any_value(); p.pos_y = any_value(); end
		endcase
		p.vel_x = any_value();
		p.vel_y = any_value();
		p.pull = any_value();
		p.step_time = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000));
		return p;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send(input particle_t p, input bit typed, input velocity_t want);
		if (!calm && $urandom_range(0, 3) == 0) begin
			particle.valid <= 0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		particle.target_x <= p.target_x;
		particle.target_y <= p.target_y;
		particle.pos_x <= p.pos_x;
		particle.pos_y <= p.pos_y;
		particle.vel_in_x <= p.vel_x;
		particle.vel_in_y <= p.vel_y;
		particle.pull <= p.pull;
		particle.step_time <= p.step_time;
		particle.valid <= 1;
		do @(posedge clk); while (!particle.ready);
		pending_vel.insert(pending_vel.size(), typed ? want : attract(p));
		@(negedge clk);
	endtask

	task automatic set_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		particle.valid <= 0;
		while (pending_vel.size() != 0) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_MAX_SPEED) speed_cap = 64'(v);
		else near_radius = 64'(v);
	endtask

	// ready side: random stall bursts until the calm tail
	initial begin
		result.ready = 0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				result.ready <= 0;
				repeat ($urandom_range(1, 16) - 1) @(negedge clk);
			end else
				result.ready <= 1;
		end
	end

	always @(posedge clk) begin
		velocity_t exp_v;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("point_attractor_velocity_step: mismatch");
			$finish;
		end
		if (arst_n && result.valid && result.ready) begin
			if (pending_vel.size() == 0) begin
				$display("error at %0t: result with no item pending", $realtime);
				errors++;
			end else begin
				exp_v = pending_vel.pop_front();
				if (result.vel_out_x !== exp_v.vel_x)
					report("vel_out_x", result.vel_out_x, exp_v.vel_x);
				if (result.vel_out_y !== exp_v.vel_y)
					report("vel_out_y", result.vel_out_y, exp_v.vel_y);
				if (result.too_close !== exp_v.too_close)
					report("too_close", result.too_close, exp_v.too_close);
				if (result.was_limited !== exp_v.was_limited)
					report("was_limited", result.was_limited, exp_v.was_limited);
			end
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		particle_t p;
		logic [CFG_W-1:0] limits[PHASES][2];
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_MAX_SPEED;
		cfg_wdata = 0;
		particle.valid = 0;
		particle.target_x = 0;
		particle.target_y = 0;
		particle.pos_x = 0;
		particle.pos_y = 0;
		particle.vel_in_x = 0;
		particle.vel_in_y = 0;
		particle.pull = 0;
		particle.step_time = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed rows at reset limits: same point, near, far, extremes
		r = '0;
		r.p = '{24'sd100, -24'sd50, 24'sd100, -24'sd50, 24'sd5, -24'sd7, 24'sd256, 16'hffff};
		r.typed = 1; r.want = '{24'sd5, -24'sd7, 1'b1, 1'b0}; rows.insert(rows.size(), r);
		r.p = '{24'sd0, 24'sd0, 24'sd100, 24'sd100, 24'sd300, 24'sd0, 24'sd9999, 16'hffff};
		r.want = '{24'sd300, 24'sd0, 1'b1, 1'b0}; rows.insert(rows.size(), r);
		r.p = '{24'sd5000, 24'sd0, 24'sd0, 24'sd0, 24'sd10, 24'sd20, 24'sd0, 16'hffff};
		r.want = '{24'sd10, 24'sd20, 1'b0, 1'b0}; rows.insert(rows.size(), r);
		r.typed = 0;
		rows.insert(rows.size(), '{'{24'sd256, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
			24'sd2560, 16'h8000}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'sd0, 24'sd256, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
			-24'sd2560, 16'h8000}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000,
			24'h7fffff, 24'h7fffff, 24'h7fffff, 16'hffff}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff,
			24'h800000, 24'h800000, 24'h7fffff, 16'hffff}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000,
			24'h800000, 24'h7fffff, 24'h800000, 16'hffff}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'sd1000, -24'sd1000, 24'sd0, 24'sd0, 24'sd30000,
			-24'sd30000, 24'sd100, 16'h0100}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'sd255, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd1,
			24'sd1000, 16'h4000}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'sd181, 24'sd181, 24'sd0, 24'sd0, 24'sd1, 24'sd1,
			24'sd1000, 16'h4000}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'sd3, -24'sd7, 24'sd0, 24'sd0, -24'sd61440, 24'sd0,
			24'sd0, 16'h0000}, 1'b0, '0});
		foreach (rows[i]) send(rows[i].p, rows[i].typed, rows[i].want);

		limits[0] = '{23'd0, 23'd0};
		limits[1] = '{23'h7fffff, 23'h7fffff};
		limits[2] = '{23'h7fffff, 23'd0};
		limits[3] = '{23'd1, 23'd3000};
		limits[4] = '{23'($urandom), 23'($urandom_range(0, 5000))};
		for (int ph = 0; ph < PHASES; ph++) begin
			set_reg(REG_MAX_SPEED, limits[ph][0]);
			set_reg(REG_MIN_DIST, limits[ph][1]);
			if (ph == 1) begin
				// the huge radius marks almost every offset too close: only offsets near the
				// extremes get through
				p = random_particle();
				send(p, 0, '0);
			end
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				if (ph == PHASES - 1 && i > RANDOM_ITEMS / PHASES / 2) calm = 1;
				send(random_particle(), 0, '0);
			end
		end
		particle.valid <= 0;
		while (pending_vel.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("point_attractor_velocity_step: match");
		else
			$display("point_attractor_velocity_step: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

/* point_attractor_velocity_step.f */
rtl/pav_pkg.sv
rtl/pav_in_if.sv
rtl/pav_out_if.sv
rtl/pav_sqrt.sv
rtl/pav_div.sv
rtl/pav_unit.sv
rtl/point_attractor_velocity_step.sv
dv/point_attractor_velocity_step_tb.sv
